### rtl/port_free_ring_allocator_macros.svh
// ----------------------------------------------------------------------------
// port free ring allocator assertion macros
// shared property forms used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef PORT_FREE_RING_ALLOCATOR_MACROS_SVH
`define PORT_FREE_RING_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define PFRA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfra assertion failed");

// next-cycle implication, off during reset
`define PFRA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfra assertion failed");

// next-cycle implication that also covers reset itself
`define PFRA_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pfra assertion failed");

`endif

### rtl/pfra_pkg.sv
// ----------------------------------------------------------------------------
// pfra_pkg
// types and constants of the port free ring allocator
// ----------------------------------------------------------------------------
package pfra_pkg;

   localparam int PORT_W     = 16;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;
   localparam int FREE_W     = 10;
   localparam int REQ_DATA_W = 3 * PORT_W;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - PORT_W - FREE_W;

   localparam logic [PORT_W-1:0] LIMIT_RESET = 16'd1023;

   typedef enum logic [ACT_W-1:0] {
      ACT_ANY,
      ACT_SPECIFIC,
      ACT_RELEASE,
      ACT_FILL
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_EMPTY,
      STAT_LIMIT,
      STAT_FULL
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ANY,
      S_SCAN,
      S_PUSH,
      S_FILL,
      S_FIN,
      S_HOLD
   } state_type;

endpackage

### rtl/port_free_ring_allocator.sv
// ----------------------------------------------------------------------------
// port_free_ring_allocator
// circular free list of port numbers kept in one synchronous memory
// ----------------------------------------------------------------------------
// Requests enter on req_ (tuser = action, tdata = port, range low, range high)
// and each gives exactly one response on rsp_ (tuser = status, tdata =
// granted port and free count). One request is worked on at a time; req_tready
// is high while the block is idle, also when a response still waits.
// From acceptance each request is worked off in the states below:
//   allocate any, release, refused requests, empty fill range: answered from
//   their working state (S_ANY, S_PUSH or S_FIN)
//   allocate specific: compares held entries from the head up to the match,
//   or all held entries when the port is not held
//   fill: range_low to range_high, one port per cycle, until the ring is full
// Reset clears the ring pointers, the free count and the response valid flag
// and sets the reserved limit to 1023; ring contents need no clearing.
// csr_wr_en writes the reserved limit; the user must write it only while no
// request is in progress, the block does not enforce it. If a response still
// waits untaken, the finished one is held in a result register and the block
// stops until it is taken; the response register never drops data.
module port_free_ring_allocator #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pfra_pkg::PORT_W-1:0]  csr_wr_data,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // port_value, range_low, range_high
   input  logic [pfra_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [pfra_pkg::ACT_W-1:0]   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // granted_port, free_ports, zero fill
   output logic [pfra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [pfra_pkg::STAT_W-1:0]  rsp_tuser
);
   import pfra_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = (IDX_W > FREE_W) ? IDX_W : FREE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      idx_next = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   logic [PORT_W-1:0] ring_mem [RING_DEPTH];
   logic [PORT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [PORT_W-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  free_ff, free_in;
   logic [PORT_W-1:0] limit_ff, limit_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [PORT_W-1:0] high_ff, high_in;
   logic [PORT_W-1:0] fill_ff, fill_in;
   status_type        stat_ff, stat_in;
   logic [IDX_W-1:0]  iss_ptr_ff, iss_ptr_in;
   logic [IDX_W-1:0]  iss_cnt_ff, iss_cnt_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]  cmp_addr_ff, cmp_addr_in;
   logic              cmp_first_ff, cmp_first_in;
   logic [PORT_W-1:0] head_val_ff, head_val_in;
   logic [PORT_W-1:0] res_port_ff, res_port_in;
   status_type        res_stat_ff, res_stat_in;
   logic [FREE_W-1:0] res_free_ff, res_free_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;

   logic              acc;
   logic              slot_free;
   action_type        req_act;
   logic [PORT_W-1:0] req_port;
   logic [PORT_W-1:0] req_low;
   logic [PORT_W-1:0] req_high;

   assign req_port = req_tdata[PORT_W-1:0];
   assign req_low  = req_tdata[2*PORT_W-1:PORT_W];
   assign req_high = req_tdata[3*PORT_W-1:2*PORT_W];
   assign req_act  = action_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_free_ff, rsp_port_ff};
   assign rsp_tuser  = rsp_stat_ff;

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_comb begin
      logic              fin_en;
      logic [PORT_W-1:0] fin_port;
      status_type        fin_stat;
      logic [CNT_W-1:0]  free_wide;
      logic              iss_ok;
      logic              fill_stop;
      action_type        act;

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      port_in      = port_ff;
      high_in      = high_ff;
      fill_in      = fill_ff;
      stat_in      = stat_ff;
      iss_ptr_in   = iss_ptr_ff;
      iss_cnt_in   = iss_cnt_ff;
      cmp_v_in     = cmp_v_ff;
      cmp_addr_in  = cmp_addr_ff;
      cmp_first_in = cmp_first_ff;
      head_val_in  = head_val_ff;
      res_port_in  = res_port_ff;
      res_stat_in  = res_stat_ff;
      res_free_in  = res_free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_port_in  = rsp_port_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_free_in  = rsp_free_ff;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = port_ff;
      fin_en       = 1'b0;
      fin_port     = '0;
      fin_stat     = STAT_OK;
      iss_ok       = iss_cnt_ff < free_ff;
      fill_stop    = (fill_ff != '0) && (free_ff == LAST_IDX);
      act          = (req_act == ACT_SPECIFIC && req_port == '0) ? ACT_ANY : req_act;

      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               port_in = req_port;
               high_in = req_high;
               fill_in = req_low;
               unique case (act)
                  ACT_ANY: begin
                     state_in = S_ANY;
                  end
                  ACT_SPECIFIC: begin
                     if (req_port > limit_ff) begin
                        stat_in  = STAT_LIMIT;
                        state_in = S_FIN;
                     end else begin
                        cmp_v_in     = (free_ff != '0);
                        cmp_addr_in  = head_ff;
                        cmp_first_in = 1'b1;
                        iss_ptr_in   = idx_next(head_ff);
                        iss_cnt_in   = IDX_W'(1);
                        state_in     = S_SCAN;
                     end
                  end
                  ACT_RELEASE: begin
                     if (req_port == '0) begin
                        stat_in  = STAT_FULL;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_PUSH;
                     end
                  end
                  ACT_FILL: begin
                     stat_in  = STAT_OK;
                     state_in = (req_low > req_high) ? S_FIN : S_FILL;
                  end
               endcase
            end
         end
         S_ANY: begin
            fin_en = 1'b1;
            if (free_ff == '0) begin
               fin_stat = STAT_EMPTY;
            end else begin
               fin_port = rd_data_ff;
               head_in  = idx_next(head_ff);
               free_in  = free_ff - 1'b1;
            end
         end
         S_SCAN: begin
            rd_addr = iss_ptr_ff;
            if (!cmp_v_ff) begin
               fin_en   = 1'b1;
               fin_stat = STAT_EMPTY;
            end else if (rd_data_ff == port_ff) begin
               // move the head entry into the matched slot, then pop the head
               wr_en    = 1'b1;
               wr_addr  = cmp_addr_ff;
               wr_data  = cmp_first_ff ? rd_data_ff : head_val_ff;
               head_in  = idx_next(head_ff);
               free_in  = free_ff - 1'b1;
               fin_en   = 1'b1;
               fin_port = port_ff;
            end else begin
               if (cmp_first_ff) begin
                  head_val_in = rd_data_ff;
               end
               cmp_v_in     = iss_ok;
               cmp_addr_in  = iss_ptr_ff;
               cmp_first_in = 1'b0;
               if (iss_ok) begin
                  iss_ptr_in = idx_next(iss_ptr_ff);
                  iss_cnt_in = iss_cnt_ff + 1'b1;
               end
            end
         end
         S_PUSH: begin
            fin_en = 1'b1;
            if (free_ff == LAST_IDX) begin
               fin_stat = STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               tail_in = idx_next(tail_ff);
               free_in = free_ff + 1'b1;
            end
         end
         S_FILL: begin
            wr_data = fill_ff;
            if (fill_stop) begin
               stat_in  = STAT_FULL;
               state_in = S_FIN;
            end else begin
               if (fill_ff != '0) begin
                  wr_en   = 1'b1;
                  tail_in = idx_next(tail_ff);
                  free_in = free_ff + 1'b1;
               end
               if (fill_ff == high_ff) begin
                  state_in = S_FIN;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            fin_en   = 1'b1;
            fin_stat = stat_ff;
         end
         S_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_port_in  = res_port_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_free_in  = res_free_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      free_wide = CNT_W'(free_in);
      if (fin_en) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_port_in  = fin_port;
            rsp_stat_in  = fin_stat;
            rsp_free_in  = free_wide[FREE_W-1:0];
            state_in     = S_IDLE;
         end else begin
            res_port_in = fin_port;
            res_stat_in = fin_stat;
            res_free_in = free_wide[FREE_W-1:0];
            state_in    = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         cmp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_v_ff     <= cmp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff      <= port_in;
      high_ff      <= high_in;
      fill_ff      <= fill_in;
      stat_ff      <= stat_in;
      iss_ptr_ff   <= iss_ptr_in;
      iss_cnt_ff   <= iss_cnt_in;
      cmp_addr_ff  <= cmp_addr_in;
      cmp_first_ff <= cmp_first_in;
      head_val_ff  <= head_val_in;
      res_port_ff  <= res_port_in;
      res_stat_ff  <= res_stat_in;
      res_free_ff  <= res_free_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_free_ff  <= rsp_free_in;
   end

endmodule

### rtl/pfra_checker.sv
// ----------------------------------------------------------------------------
// pfra_checker
// port-level checks of the port free ring allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "port_free_ring_allocator_macros.svh"

module pfra_checker #(
   parameter int RING_DEPTH = 1024
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pfra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pfra_pkg::STAT_W-1:0]     rsp_tuser
);
   import pfra_pkg::*;

   logic [PORT_W-1:0] granted;
   logic [FREE_W-1:0] free_cnt;

   assign granted  = rsp_tdata[PORT_W-1:0];
   assign free_cnt = rsp_tdata[PORT_W+FREE_W-1:PORT_W];

   // no response comes out of reset
   `PFRA_ASSERT_RST(a_reset_quiet, clock, reset, !rsp_tvalid)

   // a stalled response holds
   `PFRA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one request in progress at a time
   `PFRA_ASSERT_NXT(a_one_busy, clock, reset, req_tvalid && req_tready, !req_tready)

   // a granted port always comes with an ok status
   `PFRA_ASSERT_IMP(a_grant_ok, clock, reset, rsp_tvalid && granted != '0,
      rsp_tuser == STAT_OK)

   // the ring never reports more than it can hold
   `PFRA_ASSERT_IMP(a_free_bound, clock, reset, rsp_tvalid,
      (RING_DEPTH > 1024) || (int'(free_cnt) <= RING_DEPTH - 1))

endmodule

bind port_free_ring_allocator pfra_checker #(.RING_DEPTH(RING_DEPTH)) u_pfra_checker (.*);
